FILE: sv/tcld_pkg.sv
// ---------------------------------------------------------------------------
// tcld_pkg: shared definitions for the text command line decoder
// Command codes, character codes, keyword tables and per-byte line-state
// update functions.
// ---------------------------------------------------------------------------
package tcld_pkg;

    localparam int LINE_BUFFER_SIZE = 64;
    localparam logic [7:0] LEN_LIMIT = 8'(LINE_BUFFER_SIZE - 1);

    // Command codes
    localparam logic [3:0] CODE_PING          = 4'd0;
    localparam logic [3:0] CODE_STATUS        = 4'd1;
    localparam logic [3:0] CODE_STOP          = 4'd2;
    localparam logic [3:0] CODE_DEMO_BEGIN    = 4'd3;
    localparam logic [3:0] CODE_DEMO_CLOSE    = 4'd4;
    localparam logic [3:0] CODE_THINK         = 4'd5;
    localparam logic [3:0] CODE_MOVE          = 4'd6;
    localparam logic [3:0] CODE_MOVE_HESITATE = 4'd7;
    localparam logic [3:0] CODE_ROTATE        = 4'd8;
    localparam logic [3:0] CODE_INVALID       = 4'd9;

    // Keyword indexes in the candidate mask
    localparam int NUM_KW    = 8;
    localparam int NUM_BARE  = 6;
    localparam int KW_MOVE   = 6;
    localparam int KW_ROTATE = 7;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [3:0] POS_MAX   = 4'd15;
    localparam logic [2:0] COUNT_MAX = 3'd4;

    // Keyword text, right-justified in 80 bits (first character highest)
    localparam logic [79:0] KW_TEXT [NUM_KW] = '{
        80'("PING"), 80'("STATUS"), 80'("STOP"), 80'("DEMO_START"),
        80'("DEMO_END"), 80'("THINK"), 80'("MOVE"), 80'("ROTATE")
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd4, 4'd6, 4'd4, 4'd10, 4'd8, 4'd5, 4'd4, 4'd6
    };
    localparam logic [63:0] HES_TEXT = "HESITATE";

    typedef struct packed {
        logic [7:0] len;
        logic       ovf;
        logic       ended;
        logic [2:0] cnt;
        logic       in_tok;
        logic [3:0] pos;
        logic [7:0] kw;
        logic [4:0] arg;   // [0] RL, [1] FB, [2] face letter, [4:3] face
        logic       hes;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '{
        len: 8'd0, ovf: 1'b0, ended: 1'b0, cnt: 3'd0, in_tok: 1'b0,
        pos: 4'd0, kw: 8'hFF, arg: 5'd0, hes: 1'b0
    };

    // Character p of keyword k; zero past the keyword's end
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
        logic [3:0]  idx;
        logic [79:0] t;
        idx = KW_LEN[k] - 4'd1 - p;
        t   = KW_TEXT[k] >> {idx, 3'b000};
        return (p < KW_LEN[k]) ? t[7:0] : 8'h00;
    endfunction

    // Character p of HESITATE; zero past its end
    function automatic logic [7:0] hes_char(input logic [3:0] p);
        logic [2:0]  idx;
        logic [63:0] t;
        idx = 3'd7 - p[2:0];
        t   = HES_TEXT >> {idx, 3'b000};
        return p[3] ? 8'h00 : t[7:0];
    endfunction

    // Close the current token and drop candidates of the wrong length
    function automatic line_state_t finish_token(input line_state_t s);
        line_state_t r;
        r = s;
        if (s.in_tok) begin
            r.in_tok = 1'b0;
            if (s.cnt == 3'd1) begin
                for (int k = 0; k < NUM_KW; k++) begin
                    if (s.pos != KW_LEN[k]) begin
                        r.kw[k] = 1'b0;
                    end
                end
            end else if (s.cnt == 3'd2) begin
                if (s.pos != 4'd2) begin
                    r.arg[1:0] = 2'b00;
                end
                if (s.pos != 4'd1) begin
                    r.arg[2] = 1'b0;
                end
            end else if (s.cnt == 3'd3) begin
                if (s.pos != 4'd8) begin
                    r.hes = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // Advance the matchers by one token character
    function automatic line_state_t token_char(input line_state_t s, input logic [7:0] c);
        line_state_t r;
        logic [3:0]  p;
        r = s;
        if (!s.in_tok) begin
            r.in_tok = 1'b1;
            r.pos    = 4'd0;
            if (s.cnt < COUNT_MAX) begin
                r.cnt = s.cnt + 3'd1;
            end
            if (r.cnt == 3'd2) begin
                r.arg = 5'b00111;
            end else if (r.cnt == 3'd3) begin
                r.hes = 1'b1;
            end
        end
        p = r.pos;
        if (r.cnt == 3'd1) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (p >= KW_LEN[k] || kw_char(k, p) != c) begin
                    r.kw[k] = 1'b0;
                end
            end
        end else if (r.cnt == 3'd2) begin
            if (p >= 4'd2 || c != ((p == 4'd0) ? "R" : "L")) begin
                r.arg[0] = 1'b0;
            end
            if (p >= 4'd2 || c != ((p == 4'd0) ? "F" : "B")) begin
                r.arg[1] = 1'b0;
            end
            if (p == 4'd0) begin
                case (c)
                    "R":     r.arg[4:3] = 2'd0;
                    "L":     r.arg[4:3] = 2'd1;
                    "F":     r.arg[4:3] = 2'd2;
                    "B":     r.arg[4:3] = 2'd3;
                    default: r.arg[2]   = 1'b0;
                endcase
            end else begin
                r.arg[2] = 1'b0;
            end
        end else if (r.cnt == 3'd3) begin
            if (p >= 4'd8 || hes_char(p) != c) begin
                r.hes = 1'b0;
            end
        end
        if (r.pos < POS_MAX) begin
            r.pos = r.pos + 4'd1;
        end
        return r;
    endfunction

endpackage

FILE: sv/text_command_line_decoder_core.sv
// ---------------------------------------------------------------------------
// text_command_line_decoder_core: streaming text command line decoder
// Decodes newline-terminated command lines one byte per cycle unless stalled.
// ---------------------------------------------------------------------------
// Feed one received byte per request on the input channel. The block matches
// keywords and arguments on the fly with no line buffer and, on each newline
// that ends a line with a token (or an overflowed line), emits one result
// holding the command code, the face for MOVE codes and the axis for ROTATE.
// Carriage returns are ignored; spaces and tabs split tokens; a zero byte
// ends the line's decodable content. A line with more than LINE_BUFFER_SIZE-1
// counted bytes reports invalid. The block takes one byte per cycle back to
// back; a byte is held in the input register and its result is loaded into
// the result register. The only thing that holds input is a full result
// register whose request is stalled downstream.
module text_command_line_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] command_code,
    output logic [1:0] face,
    output logic       axis
);
    import tcld_pkg::*;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  byte_reg;

    // Line state carried from byte to byte
    line_state_t line_reg, line_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  code_reg;
    logic [1:0]  face_reg;
    logic        axis_reg;

    logic        slot_free;
    logic        advance;
    logic        res_valid;
    logic [3:0]  res_code;
    logic [1:0]  res_face;
    logic        res_axis;
    line_state_t fin;

    // The result register frees up when empty or when its request leaves
    assign slot_free = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && slot_free;
    assign in_stall  = in_valid_reg && !slot_free;

    // Per-byte decode: update the line state and form the result on newline
    always_comb
    begin
        line_next = line_reg;
        res_valid = 1'b0;
        res_code  = CODE_INVALID;
        res_face  = 2'd0;
        res_axis  = 1'b0;
        fin       = finish_token(line_reg);

        if (byte_reg == CH_LF) begin
            if (line_reg.ovf) begin
                res_valid = 1'b1;
            end else if (fin.cnt != 3'd0) begin
                res_valid = 1'b1;
                // Bare keyword: lowest surviving candidate wins
                if (fin.cnt == 3'd1) begin
                    for (int k = NUM_BARE - 1; k >= 0; k--) begin
                        if (fin.kw[k]) begin
                            res_code = 4'(k);
                        end
                    end
                end
                if (res_code == CODE_INVALID && fin.kw[KW_MOVE] && fin.arg[2]) begin
                    if (fin.cnt == 3'd2) begin
                        res_code = CODE_MOVE;
                        res_face = fin.arg[4:3];
                    end else if (fin.cnt == 3'd3 && fin.hes) begin
                        res_code = CODE_MOVE_HESITATE;
                        res_face = fin.arg[4:3];
                    end
                end
                if (res_code == CODE_INVALID && fin.kw[KW_ROTATE] && fin.cnt == 3'd2
                    && fin.arg[1:0] != 2'b00) begin
                    res_code = CODE_ROTATE;
                    res_axis = !fin.arg[0];
                end
            end
            // Start a fresh line
            line_next = LINE_CLEAR;
        end else if (byte_reg == CH_CR || line_reg.ovf) begin
            // Drop carriage returns and everything past an overflow
            line_next = line_reg;
        end else if (line_reg.len >= LEN_LIMIT) begin
            line_next.ovf = 1'b1;
        end else begin
            line_next.len = line_reg.len + 8'd1;
            if (!line_reg.ended) begin
                if (byte_reg == CH_NUL) begin
                    line_next       = fin;
                    line_next.len   = line_reg.len + 8'd1;
                    line_next.ended = 1'b1;
                end else if (byte_reg inside {CH_SPACE, CH_TAB}) begin
                    line_next     = fin;
                    line_next.len = line_reg.len + 8'd1;
                end else begin
                    line_next     = token_char(line_reg, byte_reg);
                    line_next.len = line_reg.len + 8'd1;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (slot_free) begin
            out_valid_next = advance && res_valid;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            line_reg      <= LINE_CLEAR;
        end else begin
            out_valid_reg <= out_valid_next;
            if (in_valid && !in_stall) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                line_reg <= line_next;
            end
        end
    end

    // Payload registers: hold while not loaded
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            byte_reg <= rx_byte;
        end
        if (advance && res_valid) begin
            code_reg <= res_code;
            face_reg <= res_face;
            axis_reg <= res_axis;
        end
    end

    assign out_valid    = out_valid_reg;
    assign command_code = code_reg;
    assign face         = face_reg;
    assign axis         = axis_reg;

endmodule

FILE: sv/tcld_checker.sv
// ---------------------------------------------------------------------------
// tcld_checker: port-level checks for the text command line decoder
// Watches the decoder core's ports and flags illegal result requests.
// ---------------------------------------------------------------------------
module tcld_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] command_code,
    input logic [1:0] face,
    input logic       axis
);
    import tcld_pkg::*;

    // Hold a stalled result request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(command_code)
            && $stable(face) && $stable(axis))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> command_code <= CODE_INVALID)
        else $error("command code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_code != CODE_MOVE && command_code != CODE_MOVE_HESITATE
            |-> face == 2'd0)
        else $error("face set on a non-move command");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_code != CODE_ROTATE |-> axis == 1'b0)
        else $error("axis set on a non-rotate command");

    // A fresh result traces back to a newline accepted earlier
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && rx_byte == CH_LF, 2))
        else $error("result without a newline request");

endmodule

bind text_command_line_decoder_core tcld_checker u_tcld_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .command_code (command_code),
    .face         (face),
    .axis         (axis)
);
